@@ rtl/vtb_pkg.sv @@
// shared constants, register codes and configuration type for the vertex transform block
package vtb_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int COEF_WIDTH      = 20;
  localparam int COEF_FRAC       = 18;
  localparam int ROW_WIDTH       = 3 * COEF_WIDTH;
  localparam int OFFSET_WIDTH    = 32;
  localparam int SCALE_WIDTH     = 24;
  localparam int BOUND_WIDTH     = 18;
  localparam int SUM_WIDTH       = 48;
  localparam int MARGIN_UNITS    = 10;
  localparam int MARGIN_WIDTH    = 28;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = ROW_WIDTH;

  // reset values: identity matrix, unit scale
  localparam logic [ROW_WIDTH-1:0] ROW0_RESET = ROW_WIDTH'(1) << COEF_FRAC;
  localparam logic [ROW_WIDTH-1:0] ROW1_RESET = ROW_WIDTH'(1) << (COEF_FRAC + COEF_WIDTH);
  localparam logic [ROW_WIDTH-1:0] ROW2_RESET = ROW_WIDTH'(1) << (COEF_FRAC + 2 * COEF_WIDTH);
  localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(1) << FRAC_BITS;

  // margin of ten units in unsigned Q12.16 for the rotate mode
  localparam logic [MARGIN_WIDTH-1:0] MARGIN_ROTATE = MARGIN_WIDTH'(MARGIN_UNITS << FRAC_BITS);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MODE,
    REG_ROW0,
    REG_ROW1,
    REG_ROW2,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z,
    REG_SCALE
  } reg_index_t;

  typedef enum logic {
    MODE_ROTATE = 1'b0,
    MODE_SCALE  = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                              mode;
    logic [2:0][ROW_WIDTH-1:0]          row;
    logic [2:0][OFFSET_WIDTH-1:0]       offset;
    logic [SCALE_WIDTH-1:0]             scale;
  } cfg_t;

endpackage

@@ rtl/vtb_if.sv @@
// channel interfaces: vertex input, result output and configuration write
interface vtb_vertex_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] coord_z;
  logic                          track_bounds;

  modport source (output valid, coord_x, coord_y, coord_z, track_bounds, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, track_bounds, output ready);
endinterface

interface vtb_result_if #(parameter int COORD_WIDTH = 32);
  import vtb_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic signed [BOUND_WIDTH-1:0] bound_x_low;
  logic signed [BOUND_WIDTH-1:0] bound_x_high;
  logic signed [BOUND_WIDTH-1:0] bound_y_low;
  logic signed [BOUND_WIDTH-1:0] bound_y_high;
  logic signed [BOUND_WIDTH-1:0] bound_z_low;
  logic signed [BOUND_WIDTH-1:0] bound_z_high;
  logic signed [SUM_WIDTH-1:0]   total_x;
  logic signed [SUM_WIDTH-1:0]   total_y;
  logic signed [SUM_WIDTH-1:0]   total_z;

  modport source (output valid, out_x, out_y, out_z, bound_x_low, bound_x_high,
                  bound_y_low, bound_y_high, bound_z_low, bound_z_high,
                  total_x, total_y, total_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, bound_x_low, bound_x_high,
                bound_y_low, bound_y_high, bound_z_low, bound_z_high,
                total_x, total_y, total_z, output ready);
endinterface

interface vtb_cfg_if;
  import vtb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/vtb_xform.sv @@
// transform pipeline: input register, products, rounded sums, offset and saturation
module vtb_xform #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vtb_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_coord [3],
  input  logic                          in_track,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_res [3],
  output logic                          out_track
);
  import vtb_pkg::*;

  localparam int AW = ((COORD_WIDTH > OFFSET_WIDTH) ? COORD_WIDTH : OFFSET_WIDTH) + 1;
  localparam int BW = SCALE_WIDTH + 1;
  localparam int PW = AW + BW;
  localparam int SW = PW + 2;
  localparam int QW = SW - FRAC_BITS;
  localparam int RW = QW + 1;

  localparam logic signed [SW-1:0] RND_SCALE = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] RND_ROT   = SW'(1) <<< (COEF_FRAC - 1);

  function automatic logic [COEF_WIDTH-1:0] get_coef(input logic [ROW_WIDTH-1:0] row_bits,
                                                     input int col);
    get_coef = row_bits[col * COEF_WIDTH +: COEF_WIDTH];
  endfunction

  logic                 v0, v1, v2, v3;
  logic                 en0, en1, en2, en3;
  logic                 t0, t1, t2, t3;
  logic signed [AW-1:0] a0 [3];
  logic signed [AW-1:0] a_next [3];
  logic signed [BW-1:0] b_op [3][3];
  logic signed [PW-1:0] p1 [3][3];
  logic signed [PW-1:0] p_next [3][3];
  logic signed [SW-1:0] acc [3];
  logic signed [QW-1:0] q2 [3];
  logic signed [QW-1:0] q_next [3];
  logic signed [RW-1:0] r_full [3];
  logic signed [COORD_WIDTH-1:0] res3 [3];
  logic signed [COORD_WIDTH-1:0] res_next [3];

  // stage enables: a stage loads when empty or when its content moves on
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  // multiplier operand: raw vertex, or vertex minus shift for the scale mode
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cfg.mode == MODE_SCALE) begin
        a_next[i] = AW'(in_coord[i]) - AW'($signed(cfg.offset[i]));
      end else begin
        a_next[i] = AW'(in_coord[i]);
      end
    end
  end

  // nine products; the diagonal takes the scale in scale mode
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r == c && cfg.mode == MODE_SCALE) begin
          b_op[r][c] = BW'($signed({1'b0, cfg.scale}));
        end else begin
          b_op[r][c] = BW'($signed(get_coef(cfg.row[r], c)));
        end
        p_next[r][c] = PW'(a0[c]) * PW'(b_op[r][c]);
      end
    end
  end

  // row sum, round half up, drop the fraction bits
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = SW'(p1[r][r]) + ((cfg.mode == MODE_SCALE) ? RND_SCALE : RND_ROT);
      for (int c = 0; c < 3; c++) begin
        if (c != r && cfg.mode == MODE_ROTATE) begin
          acc[r] = acc[r] + SW'(p1[r][c]);
        end
      end
      if (cfg.mode == MODE_SCALE) begin
        q_next[r] = QW'(acc[r] >>> FRAC_BITS);
      end else begin
        q_next[r] = QW'(acc[r] >>> COEF_FRAC);
      end
    end
  end

  // shift after rotation, then saturate to the coordinate range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cfg.mode == MODE_ROTATE) begin
        r_full[i] = RW'(q2[i]) - RW'($signed(cfg.offset[i]));
      end else begin
        r_full[i] = RW'(q2[i]);
      end
      if (r_full[i][RW-1:COORD_WIDTH-1] == {(RW - COORD_WIDTH + 1){r_full[i][RW-1]}}) begin
        res_next[i] = r_full[i][COORD_WIDTH-1:0];
      end else if (r_full[i][RW-1]) begin
        res_next[i] = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
      end else begin
        res_next[i] = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
      end
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
    if (en0) begin
      a0 <= a_next;
      t0 <= in_track;
    end
    if (en1) begin
      p1 <= p_next;
      t1 <= t0;
    end
    if (en2) begin
      q2 <= q_next;
      t2 <= t1;
    end
    if (en3) begin
      res3 <= res_next;
      t3   <= t2;
    end
  end

  assign out_valid = v3;
  assign out_res   = res3;
  assign out_track = t3;

endmodule

@@ rtl/vtb_track.sv @@
// bounding box and running sum tracking, with the result register
module vtb_track #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  vtb_pkg::cfg_t                         cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         in_res [3],
  input  logic                                  in_track,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH-1:0]         out_res [3],
  output logic signed [vtb_pkg::BOUND_WIDTH-1:0] out_low [3],
  output logic signed [vtb_pkg::BOUND_WIDTH-1:0] out_high [3],
  output logic signed [vtb_pkg::SUM_WIDTH-1:0]  out_sum [3]
);
  import vtb_pkg::*;

  localparam int CW1 = COORD_WIDTH + 1;
  localparam int TW  = COORD_WIDTH - FRAC_BITS + 1;
  localparam int XW  = ((TW > BOUND_WIDTH) ? TW : BOUND_WIDTH) + 1;
  localparam int EW  = ((COORD_WIDTH > 33) ? COORD_WIDTH : 33) + 2;
  localparam int MIW = MARGIN_WIDTH - FRAC_BITS;
  localparam int SXW = SUM_WIDTH + 1;

  localparam logic signed [CW1-1:0] HALF_UP   = CW1'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [CW1-1:0] HALF_DOWN = HALF_UP - CW1'(1);

  function automatic logic signed [BOUND_WIDTH-1:0] sat_bound(input logic signed [XW-1:0] x);
    if (x[XW-1:BOUND_WIDTH-1] == {(XW - BOUND_WIDTH + 1){x[XW-1]}}) begin
      sat_bound = x[BOUND_WIDTH-1:0];
    end else if (x[XW-1]) begin
      sat_bound = {1'b1, {(BOUND_WIDTH - 1){1'b0}}};
    end else begin
      sat_bound = {1'b0, {(BOUND_WIDTH - 1){1'b1}}};
    end
  endfunction

  logic v4, v5, ov;
  logic en4, en5, en_out, upd;
  logic t4, t5;

  logic [MARGIN_WIDTH-1:0]       margin;
  logic [MIW-1:0]                mi4;
  logic                          mf4;
  logic signed [COORD_WIDTH-1:0] res4 [3];
  logic signed [COORD_WIDTH-1:0] res5 [3];
  logic signed [TW-1:0]          tq4 [3];
  logic signed [TW-1:0]          tq_next [3];
  logic signed [TW-1:0]          rnd4 [3];
  logic signed [TW-1:0]          rnd5 [3];
  logic signed [TW-1:0]          rnd_next [3];
  logic signed [EW-1:0]          rml4 [3];
  logic signed [EW-1:0]          rmh4 [3];
  logic signed [EW-1:0]          rml5 [3];
  logic signed [EW-1:0]          rmh5 [3];
  logic signed [EW-1:0]          rml_next [3];
  logic signed [EW-1:0]          rmh_next [3];
  logic signed [XW-1:0]          lo_diff [3];
  logic signed [XW-1:0]          hi_diff [3];
  logic signed [BOUND_WIDTH-1:0] lo_cand_next [3];
  logic signed [BOUND_WIDTH-1:0] hi_cand_next [3];
  logic signed [BOUND_WIDTH-1:0] lo_cand [3];
  logic signed [BOUND_WIDTH-1:0] hi_cand [3];
  logic signed [SXW-1:0]         sum_wide [3];

  logic signed [BOUND_WIDTH-1:0] box_low [3];
  logic signed [BOUND_WIDTH-1:0] box_high [3];
  logic signed [SUM_WIDTH-1:0]   coord_sum [3];
  logic signed [BOUND_WIDTH-1:0] box_low_next [3];
  logic signed [BOUND_WIDTH-1:0] box_high_next [3];
  logic signed [SUM_WIDTH-1:0]   coord_sum_next [3];

  // stage enables and the state update strobe
  assign en_out   = !ov || out_ready;
  assign en5      = !v5 || en_out;
  assign en4      = !v4 || en5;
  assign in_ready = en4;
  assign upd      = v5 && en_out;

  // margin: ten units, scaled in scale mode
  always_comb begin
    if (cfg.mode == MODE_SCALE) begin
      margin = MARGIN_WIDTH'(cfg.scale) * MARGIN_WIDTH'(MARGIN_UNITS);
    end else begin
      margin = MARGIN_ROTATE;
    end
  end

  // truncated integer part, rounded value and margin-shifted coordinates
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tq_next[i] = TW'(in_res[i] >>> FRAC_BITS) +
                   ((in_res[i][COORD_WIDTH-1] && (|in_res[i][FRAC_BITS-1:0])) ?
                    TW'(1) : TW'(0));
      rnd_next[i] = TW'((CW1'(in_res[i]) +
                         (in_res[i][COORD_WIDTH-1] ? HALF_DOWN : HALF_UP)) >>> FRAC_BITS);
      rml_next[i] = EW'(in_res[i]) - EW'($signed({1'b0, margin}));
      rmh_next[i] = EW'(in_res[i]) + EW'($signed({1'b0, margin}));
    end
  end

  // candidate limits: truncate toward zero of integer part minus or plus margin
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_diff[i] = XW'(tq4[i]) - XW'($signed({1'b0, mi4}));
      hi_diff[i] = XW'(tq4[i]) + XW'($signed({1'b0, mi4}));
      if (mf4 && lo_diff[i] > XW'(0)) begin
        lo_cand_next[i] = sat_bound(lo_diff[i] - XW'(1));
      end else begin
        lo_cand_next[i] = sat_bound(lo_diff[i]);
      end
      if (mf4 && hi_diff[i] < XW'(0)) begin
        hi_cand_next[i] = sat_bound(hi_diff[i] + XW'(1));
      end else begin
        hi_cand_next[i] = sat_bound(hi_diff[i]);
      end
    end
  end

  // widen the box against the old limits, accumulate sums with saturation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      box_low_next[i]  = box_low[i];
      box_high_next[i] = box_high[i];
      if (t5 && rml5[i] < (EW'(box_low[i]) <<< FRAC_BITS)) begin
        box_low_next[i] = lo_cand[i];
      end
      if (t5 && rmh5[i] > (EW'(box_high[i]) <<< FRAC_BITS)) begin
        box_high_next[i] = hi_cand[i];
      end
      sum_wide[i] = SXW'(coord_sum[i]) + SXW'(rnd5[i]);
      if (cfg.mode == MODE_ROTATE) begin
        coord_sum_next[i] = coord_sum[i];
      end else if (sum_wide[i][SXW-1] == sum_wide[i][SXW-2]) begin
        coord_sum_next[i] = sum_wide[i][SUM_WIDTH-1:0];
      end else if (sum_wide[i][SXW-1]) begin
        coord_sum_next[i] = {1'b1, {(SUM_WIDTH - 1){1'b0}}};
      end else begin
        coord_sum_next[i] = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
      end
    end
  end

  // pipeline, state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      ov <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        box_low[i]   <= '0;
        box_high[i]  <= '0;
        coord_sum[i] <= '0;
      end
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en_out) ov <= v5;
      if (upd) begin
        box_low   <= box_low_next;
        box_high  <= box_high_next;
        coord_sum <= coord_sum_next;
      end
    end
    if (en4) begin
      res4 <= in_res;
      t4   <= in_track;
      tq4  <= tq_next;
      rnd4 <= rnd_next;
      rml4 <= rml_next;
      rmh4 <= rmh_next;
      mi4  <= margin[MARGIN_WIDTH-1:FRAC_BITS];
      mf4  <= |margin[FRAC_BITS-1:0];
    end
    if (en5) begin
      res5    <= res4;
      t5      <= t4;
      rnd5    <= rnd4;
      rml5    <= rml4;
      rmh5    <= rmh4;
      lo_cand <= lo_cand_next;
      hi_cand <= hi_cand_next;
    end
    if (en_out) begin
      out_res  <= res5;
      out_low  <= box_low_next;
      out_high <= box_high_next;
      out_sum  <= coord_sum_next;
    end
  end

  assign out_valid = ov;

  // state only moves when an item passes into the result register
  for (genvar g = 0; g < 3; g++) begin : g_chk
    a_state_hold: assert property (@(posedge clk) disable iff (rst)
      !upd |=> $stable(box_low[g]) && $stable(box_high[g]) && $stable(coord_sum[g]))
      else $error("tracking state changed without an update");

    a_untracked_box: assert property (@(posedge clk) disable iff (rst)
      (upd && !t5) |=> $stable(box_low[g]) && $stable(box_high[g]))
      else $error("box changed for an untracked vertex");

    a_rotate_sum: assert property (@(posedge clk) disable iff (rst)
      (upd && cfg.mode == MODE_ROTATE) |=> $stable(coord_sum[g]))
      else $error("sum changed in rotate mode");

    a_sum_grows: assert property (@(posedge clk) disable iff (rst)
      (upd && cfg.mode == MODE_SCALE && !rnd5[g][TW-1]) |=>
      coord_sum[g] >= $past(coord_sum[g]))
      else $error("sum fell after adding a non-negative value");
  end

endmodule

@@ rtl/vertex_transform_bounds_unit.sv @@
// top level of the vertex transform and bounding box unit
// Takes one signed Q16.16 vertex per cycle unless stalled; one result per vertex, in order.
// Mode 0 rotates by the 3x3 Q2.18 matrix, rounds half up and subtracts the offset; mode 1
// subtracts the offset, scales by the Q8.16 scale and rounds half up. Results saturate to
// the coordinate range. Tracked vertices widen the integer bounding box by a margin of ten
// units (ten times the scale in mode 1); mode 1 also adds the rounded coordinates into
// saturating 48-bit sums. Each result carries the box and sums after its own update.
// Throughput is one vertex per clock unless the result channel stalls; a result reaches
// the result register through the input, product, rounding, saturation and two tracking
// stages. The box and sum update is a feedback loop in the last stage. Back pressure
// stalls only the stages that are full. The user must write registers only while no
// vertex is in flight (the block does not enforce it); the cfg channel is always ready.
module vertex_transform_bounds_unit #(
  parameter int COORD_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  vtb_vertex_if.sink  vertex,
  vtb_result_if.source result,
  vtb_cfg_if.sink     cfg
);
  import vtb_pkg::*;

  cfg_t cfg_regs;

  logic signed [COORD_WIDTH-1:0] in_coord [3];
  logic                          x_valid;
  logic                          x_ready;
  logic signed [COORD_WIDTH-1:0] x_res [3];
  logic                          x_track;
  logic signed [COORD_WIDTH-1:0] res [3];
  logic signed [BOUND_WIDTH-1:0] low [3];
  logic signed [BOUND_WIDTH-1:0] high [3];
  logic signed [SUM_WIDTH-1:0]   sum [3];

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.mode   <= MODE_ROTATE;
      cfg_regs.row[0] <= ROW0_RESET;
      cfg_regs.row[1] <= ROW1_RESET;
      cfg_regs.row[2] <= ROW2_RESET;
      cfg_regs.offset <= '0;
      cfg_regs.scale  <= SCALE_RESET;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_MODE:     cfg_regs.mode      <= mode_t'(cfg.data[0]);
        REG_ROW0:     cfg_regs.row[0]    <= cfg.data[ROW_WIDTH-1:0];
        REG_ROW1:     cfg_regs.row[1]    <= cfg.data[ROW_WIDTH-1:0];
        REG_ROW2:     cfg_regs.row[2]    <= cfg.data[ROW_WIDTH-1:0];
        REG_OFFSET_X: cfg_regs.offset[0] <= cfg.data[OFFSET_WIDTH-1:0];
        REG_OFFSET_Y: cfg_regs.offset[1] <= cfg.data[OFFSET_WIDTH-1:0];
        REG_OFFSET_Z: cfg_regs.offset[2] <= cfg.data[OFFSET_WIDTH-1:0];
        REG_SCALE:    cfg_regs.scale     <= cfg.data[SCALE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // vertex channel into the transform pipeline
  assign in_coord[0] = vertex.coord_x;
  assign in_coord[1] = vertex.coord_y;
  assign in_coord[2] = vertex.coord_z;

  vtb_xform #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_xform (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .in_valid  (vertex.valid),
    .in_ready  (vertex.ready),
    .in_coord  (in_coord),
    .in_track  (vertex.track_bounds),
    .out_valid (x_valid),
    .out_ready (x_ready),
    .out_res   (x_res),
    .out_track (x_track)
  );

  vtb_track #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .in_valid  (x_valid),
    .in_ready  (x_ready),
    .in_res    (x_res),
    .in_track  (x_track),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_res   (res),
    .out_low   (low),
    .out_high  (high),
    .out_sum   (sum)
  );

  // result channel fields
  assign result.out_x        = res[0];
  assign result.out_y        = res[1];
  assign result.out_z        = res[2];
  assign result.bound_x_low  = low[0];
  assign result.bound_x_high = high[0];
  assign result.bound_y_low  = low[1];
  assign result.bound_y_high = high[1];
  assign result.bound_z_low  = low[2];
  assign result.bound_z_high = high[2];
  assign result.total_x      = sum[0];
  assign result.total_y      = sum[1];
  assign result.total_z      = sum[2];

endmodule

@@ bench/tb_vertex_transform_bounds_unit.sv @@
// self-checking testbench for the vertex transform and bounding box unit
module tb_vertex_transform_bounds_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import vtb_pkg::*;

  localparam int COORD_WIDTH     = 32;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int SETTLE_CYCLES   = 12;
  localparam int CYCLE_LIMIT     = 200000;
  localparam longint Q_ONE       = 64'sd1 <<< FRAC_BITS;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] coord[3];
    bit                            track;
  } vertex_item_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] coord[3];
    logic signed [BOUND_WIDTH-1:0] low[3];
    logic signed [BOUND_WIDTH-1:0] high[3];
    logic signed [SUM_WIDTH-1:0]   total[3];
  } vertex_result_t;

  // transform predictor with its own copy of registers, box and sums
  class vertex_scoreboard;
    mode_t                mode;
    logic [ROW_WIDTH-1:0] row[3];
    longint               offset[3];
    longint               scale;
    longint               box_low[3];
    longint               box_high[3];
    longint               coord_total[3];
    vertex_result_t       pending_results[$];
    string                axis_name[3] = '{"x", "y", "z"};
    int                   failures;

    function new();
      mode   = MODE_ROTATE;
      row[0] = ROW0_RESET;
      row[1] = ROW1_RESET;
      row[2] = ROW2_RESET;
      scale  = longint'(SCALE_RESET);
      for (int i = 0; i < 3; i++) begin
        offset[i]      = 0;
        box_low[i]     = 0;
        box_high[i]    = 0;
        coord_total[i] = 0;
      end
      failures = 0;
    endfunction

    function longint saturate(longint value, int width);
      longint top;
      longint bottom;
      top    = (64'sd1 <<< (width - 1)) - 1;
      bottom = -top - 1;
      if (value > top) return top;
      if (value < bottom) return bottom;
      return value;
    endfunction

    function void set_register(reg_index_t idx, logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_MODE:     mode = mode_t'(data[0]);
        REG_ROW0:     row[0] = data[ROW_WIDTH-1:0];
        REG_ROW1:     row[1] = data[ROW_WIDTH-1:0];
        REG_ROW2:     row[2] = data[ROW_WIDTH-1:0];
        REG_OFFSET_X: offset[0] = longint'($signed(data[OFFSET_WIDTH-1:0]));
        REG_OFFSET_Y: offset[1] = longint'($signed(data[OFFSET_WIDTH-1:0]));
        REG_OFFSET_Z: offset[2] = longint'($signed(data[OFFSET_WIDTH-1:0]));
        REG_SCALE:    scale = longint'(data[SCALE_WIDTH-1:0]);
        default: ;
      endcase
    endfunction

    function vertex_result_t transform_vertex(vertex_item_t item);
      vertex_result_t r;
      longint v[3];
      longint res[3];
      longint margin, whole, frac_acc, hi, lo, coef, diff, trunc_val, mag, step;
      int i, c;
      for (i = 0; i < 3; i++) v[i] = longint'(item.coord[i]);

      if (mode == MODE_ROTATE) begin
        // split each coordinate so products stay exact, round half up once
        for (i = 0; i < 3; i++) begin
          whole = 0;
          frac_acc = 0;
          for (c = 0; c < 3; c++) begin
            hi = v[c] >>> COEF_FRAC;
            lo = v[c] - (hi <<< COEF_FRAC);
            coef = longint'($signed(row[i][COEF_WIDTH*c +: COEF_WIDTH]));
            whole += coef * hi;
            frac_acc += coef * lo;
          end
          whole += (frac_acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
          res[i] = saturate(whole - offset[i], COORD_WIDTH);
        end
        margin = longint'(MARGIN_UNITS) * Q_ONE;
      end else begin
        // shift first, then scale with round half up
        for (i = 0; i < 3; i++) begin
          diff = v[i] - offset[i];
          hi = diff >>> FRAC_BITS;
          lo = diff - (hi <<< FRAC_BITS);
          res[i] = saturate(hi * scale + ((lo * scale + Q_ONE / 2) >>> FRAC_BITS),
                            COORD_WIDTH);
        end
        margin = longint'(MARGIN_UNITS) * scale;
      end

      // box widening against the old limits
      if (item.track) begin
        for (i = 0; i < 3; i++) begin
          trunc_val = res[i] / Q_ONE;
          if (res[i] < box_low[i] * Q_ONE + margin) begin
            lo = saturate((trunc_val * Q_ONE - margin) / Q_ONE, BOUND_WIDTH);
          end else begin
            lo = box_low[i];
          end
          if (res[i] > box_high[i] * Q_ONE - margin) begin
            box_high[i] = saturate((trunc_val * Q_ONE + margin) / Q_ONE, BOUND_WIDTH);
          end
          box_low[i] = lo;
        end
      end

      // running sums of coordinates rounded half away from zero
      if (mode == MODE_SCALE) begin
        for (i = 0; i < 3; i++) begin
          mag = (res[i] < 0) ? -res[i] : res[i];
          step = (mag + Q_ONE / 2) >>> FRAC_BITS;
          coord_total[i] = saturate(coord_total[i] + ((res[i] < 0) ? -step : step),
                                    SUM_WIDTH);
        end
      end

      for (i = 0; i < 3; i++) begin
        r.coord[i] = res[i][COORD_WIDTH-1:0];
        r.low[i]   = box_low[i][BOUND_WIDTH-1:0];
        r.high[i]  = box_high[i][BOUND_WIDTH-1:0];
        r.total[i] = coord_total[i][SUM_WIDTH-1:0];
      end
      return r;
    endfunction

    function void note_vertex(vertex_item_t item);
      pending_results.push_back(transform_vertex(item));
    endfunction

    function void check_result(vertex_result_t got);
      vertex_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no vertex pending: out_x=%0d", got.coord[0]);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.coord[i] !== want.coord[i]) begin
          $error("out_%s: expected %0d, got %0d", axis_name[i], want.coord[i], got.coord[i]);
          failures++;
        end
        if (got.low[i] !== want.low[i]) begin
          $error("bound_%s_low: expected %0d, got %0d", axis_name[i], want.low[i], got.low[i]);
          failures++;
        end
        if (got.high[i] !== want.high[i]) begin
          $error("bound_%s_high: expected %0d, got %0d", axis_name[i], want.high[i],
                 got.high[i]);
          failures++;
        end
        if (got.total[i] !== want.total[i]) begin
          $error("total_%s: expected %0d, got %0d", axis_name[i], want.total[i],
                 got.total[i]);
          failures++;
        end
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int send_pattern[4] = '{0, 52, 0, 24};
  int recv_pattern[4] = '{0, 0, 52, 24};
  vertex_scoreboard sb = new();

  vtb_vertex_if #(.COORD_WIDTH(COORD_WIDTH)) vertex_ch ();
  vtb_result_if #(.COORD_WIDTH(COORD_WIDTH)) result_ch ();
  vtb_cfg_if cfg_ch ();

  vertex_transform_bounds_unit #(.COORD_WIDTH(COORD_WIDTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[vertex_transform_bounds_unit] ERROR");
      $finish;
    end
  end

  // receiver back pressure
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result transfer check
  always @(posedge clk) begin : result_monitor
    vertex_result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.coord[0] = result_ch.out_x;
      got.coord[1] = result_ch.out_y;
      got.coord[2] = result_ch.out_z;
      got.low[0]   = result_ch.bound_x_low;
      got.high[0]  = result_ch.bound_x_high;
      got.low[1]   = result_ch.bound_y_low;
      got.high[1]  = result_ch.bound_y_high;
      got.low[2]   = result_ch.bound_z_low;
      got.high[2]  = result_ch.bound_z_high;
      got.total[0] = result_ch.total_x;
      got.total[1] = result_ch.total_y;
      got.total[2] = result_ch.total_z;
      sb.check_result(got);
    end
  end

  // random coordinate, mostly within +-2^(reach-1) LSB
  function automatic logic signed [31:0] rand_coord(int reach);
    logic signed [31:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0: begin
        if (reach >= 32) return raw[0] ? 32'sh7FFFFFFF : 32'sh80000000;
        return 32'sd0;
      end
      1: return raw[0] ? 32'sd1 : -32'sd1;
      2: return ((raw >>> (32 - reach)) & 32'shFFFF0000) | (raw[1] ? 32'sh8000 : 32'sh0);
      default: return raw >>> (32 - reach);
    endcase
  endfunction

  function automatic cfg_t make_setting(mode_t m, logic [ROW_WIDTH-1:0] r0, r1, r2,
                                        logic [31:0] ox, oy, oz,
                                        logic [SCALE_WIDTH-1:0] sc);
    cfg_t s;
    s.mode      = m;
    s.row[0]    = r0;
    s.row[1]    = r1;
    s.row[2]    = r2;
    s.offset[0] = ox;
    s.offset[1] = oy;
    s.offset[2] = oz;
    s.scale     = sc;
    return s;
  endfunction

  function automatic cfg_t random_setting(int phase, int reach);
    cfg_t s;
    logic [COEF_WIDTH-1:0] coef_bits;
    logic [31:0] raw;
    s.mode = mode_t'(phase[0]);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        raw = $urandom;
        case ($urandom_range(3))
          0: coef_bits = raw[COEF_WIDTH-1:0];
          1: coef_bits = raw[20] ? 20'h40000 : 20'hC0000;
          2: coef_bits = {{4{raw[15]}}, raw[15:0]};
          default: begin
            case (raw[21:20])
              2'd0: coef_bits = 20'h7FFFF;
              2'd1: coef_bits = 20'h80000;
              default: coef_bits = 20'h00000;
            endcase
          end
        endcase
        s.row[r][COEF_WIDTH*c +: COEF_WIDTH] = coef_bits;
      end
      s.offset[r] = rand_coord(reach);
    end
    case ($urandom_range(4))
      0: s.scale = '0;
      1: s.scale = '1;
      2: s.scale = SCALE_RESET;
      3: s.scale = SCALE_WIDTH'($urandom_range(32'h20000));
      default: s.scale = SCALE_WIDTH'($urandom);
    endcase
    return s;
  endfunction

  // one register write; valid stays up for a following write
  task automatic load_register(reg_index_t idx, logic [CFG_DATA_WIDTH-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_register(idx, data);
  endtask

  task automatic apply_setting(cfg_t s);
    load_register(REG_MODE, CFG_DATA_WIDTH'(s.mode));
    load_register(REG_ROW0, CFG_DATA_WIDTH'(s.row[0]));
    load_register(REG_ROW1, CFG_DATA_WIDTH'(s.row[1]));
    load_register(REG_ROW2, CFG_DATA_WIDTH'(s.row[2]));
    load_register(REG_OFFSET_X, CFG_DATA_WIDTH'(s.offset[0]));
    load_register(REG_OFFSET_Y, CFG_DATA_WIDTH'(s.offset[1]));
    load_register(REG_OFFSET_Z, CFG_DATA_WIDTH'(s.offset[2]));
    load_register(REG_SCALE, CFG_DATA_WIDTH'(s.scale));
    cfg_ch.valid <= 1'b0;
  endtask

  // one vertex transfer, with random sender gaps in front
  task automatic send_vertex(logic signed [31:0] x, y, z, bit track);
    vertex_item_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      vertex_ch.valid <= 1'b0;
      @(posedge clk);
    end
    vertex_ch.valid        <= 1'b1;
    vertex_ch.coord_x      <= x;
    vertex_ch.coord_y      <= y;
    vertex_ch.coord_z      <= z;
    vertex_ch.track_bounds <= track;
    do @(posedge clk); while (vertex_ch.ready !== 1'b1);
    item.coord[0] = x;
    item.coord[1] = y;
    item.coord[2] = z;
    item.track    = track;
    sb.note_vertex(item);
  endtask

  // stop sending and wait until the pipeline is empty
  task automatic drain_pipeline();
    vertex_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int reach;
    vertex_ch.valid        <= 1'b0;
    vertex_ch.coord_x      <= '0;
    vertex_ch.coord_y      <= '0;
    vertex_ch.coord_z      <= '0;
    vertex_ch.track_bounds <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= REG_MODE;
    cfg_ch.data            <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset setting: identity rotate, small box growth, tracking off cases
    send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
    send_vertex(32'sh50000, -32'sh50000, 32'sh8000, 1'b1);
    send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
    send_vertex(32'sh80000000, 32'sh7FFFFFFF, -32'sd1, 1'b0);
    send_vertex(32'sh144000, -32'sh1EC000, 32'shB0000, 1'b1);
    send_vertex(32'sh30000, 32'sh40000, -32'sh20000, 1'b0);

    // extreme coefficients and offsets, half-LSB rounding in z
    drain_pipeline();
    apply_setting(make_setting(MODE_ROTATE, {20'h7FFFF, 20'h80000, 20'h7FFFF},
                               {20'h80000, 20'h80000, 20'h80000},
                               {20'h00000, 20'h00000, 20'h00001},
                               32'h7FFFFFFF, 32'h80000000, 32'h0, SCALE_RESET));
    send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    send_vertex(32'sh20000, 32'sd0, 32'sd0, 1'b0);
    send_vertex(-32'sh20000, 32'sd0, 32'sd0, 1'b0);
    send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b0);

    // half scale: rounding of odd differences
    drain_pipeline();
    apply_setting(make_setting(MODE_SCALE, ROW0_RESET, ROW1_RESET, ROW2_RESET,
                               32'h1, 32'hFFFFFFFF, 32'h0, 24'h008000));
    send_vertex(32'sd2, 32'sd0, 32'sd1, 1'b1);
    send_vertex(32'sd0, -32'sd2, -32'sd1, 1'b1);
    send_vertex(32'sh10001, -32'shFFFF, 32'sh28001, 1'b1);

    // unit scale: sums round half away from zero
    drain_pipeline();
    apply_setting(make_setting(MODE_SCALE, ROW0_RESET, ROW1_RESET, ROW2_RESET,
                               32'h0, 32'h0, 32'h0, SCALE_RESET));
    send_vertex(32'sh8000, -32'sh8000, 32'sh18000, 1'b1);
    send_vertex(32'sh7FFF, -32'sh7FFF, 32'sd0, 1'b1);

    // largest scale with extreme offsets: saturation
    drain_pipeline();
    apply_setting(make_setting(MODE_SCALE, ROW0_RESET, ROW1_RESET, ROW2_RESET,
                               32'h80000000, 32'h7FFFFFFF, 32'h0, 24'hFFFFFF));
    send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 1'b0);
    send_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh10000, 1'b0);

    // zero scale: zero margin
    drain_pipeline();
    apply_setting(make_setting(MODE_SCALE, ROW0_RESET, ROW1_RESET, ROW2_RESET,
                               32'h0, 32'h0, 32'h0, 24'h000000));
    send_vertex(32'sh7FFFFFFF, 32'sd123, 32'sh80000000, 1'b1);

    // random phases with growing coordinate reach and rotating idle patterns
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      reach = (20 + 2 * phase > 32) ? 32 : 20 + 2 * phase;
      drain_pipeline();
      send_idle_pct  = send_pattern[phase % 4];
      recv_stall_pct = recv_pattern[phase % 4];
      apply_setting(random_setting(phase, reach));
      repeat (ITEMS_PER_PHASE) begin
        send_vertex(rand_coord(reach), rand_coord(reach), rand_coord(reach),
                    $urandom_range(9) < 7);
      end
    end

    drain_pipeline();
    if (sb.failures == 0) begin
      $display("[vertex_transform_bounds_unit] OK");
    end else begin
      $display("[vertex_transform_bounds_unit] ERROR");
    end
    $finish;
  end

endmodule
